### hdl/coordinate_hash_map_macros.svh
`ifndef COORDINATE_HASH_MAP_MACROS_SVH
`define COORDINATE_HASH_MAP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/chm_pkg.sv
package chm_pkg;

  localparam int BUCKETS = 64;
  localparam int ENTRIES = 256;
  localparam int BW      = $clog2(BUCKETS);
  localparam int EW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(ENTRIES + 1);

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_UPDATED = 3'd1;
  localparam logic [2:0] ST_FOUND   = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_REMOVED = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;

  typedef struct packed {
    logic [1:0]    operation;
    logic [15:0]   key_x;
    logic [15:0]   key_y;
    logic [31:0]   value_in;
    logic [BW-1:0] bucket;
  } req_t;

  // low bits of the product depend only on low bits of the operands
  function automatic logic [BW-1:0] hash_round(input logic [BW-1:0] h, input logic [15:0] k);
    logic [2*BW-1:0] p;
    p = (h ^ k[BW-1:0]) * FNV_PRIME[BW-1:0];
    return p[BW-1:0];
  endfunction

endpackage

### hdl/chm_front.sv
module chm_front import chm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [15:0] key_x,
  input  logic [15:0] key_y,
  input  logic [31:0] value_in,
  output logic        q_push,
  output req_t        q_data,
  input  logic        q_full
);

  logic          busy;
  logic [BW-1:0] h1;
  req_t          req;

  assign full   = busy;
  assign q_push = busy && !q_full;

  always_comb begin
    q_data        = req;
    q_data.bucket = hash_round(h1, req.key_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (push && !busy) begin
      busy <= 1'b1;
    end else if (q_push) begin
      busy <= 1'b0;
    end
    if (push && !busy) begin
      req.operation <= operation;
      req.key_x     <= key_x;
      req.key_y     <= key_y;
      req.value_in  <= value_in;
      req.bucket    <= '0;
      h1            <= hash_round(FNV_BASIS[BW-1:0], key_x);
    end
  end

endmodule

### hdl/chm_queue.sv
module chm_queue import chm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t din,
  output logic full,
  input  logic pop,
  output req_t dout,
  output logic empty
);

  logic [1:0] cnt;
  req_t       slot0;
  req_t       slot1;
  logic       wr;
  logic       rd;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = slot0;
  assign wr    = push && !full;
  assign rd    = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
    if (rd) begin
      slot0 <= (cnt == 2'd2) ? slot1 : din;
      if (wr && cnt == 2'd2) begin
        slot1 <= din;
      end
    end else if (wr) begin
      if (cnt == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end
  end

endmodule

### hdl/chm_back.sv
module chm_back import chm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  req_t        q_data,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [31:0] value_out,
  output logic [8:0]  entry_total
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_HEAD   = 6'b000010,
    S_READ   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_LINK   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  req_t   req;

  logic [EW-1:0]   head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_valid;
  logic [EW-1:0]   head_q;
  logic            head_we;
  logic [EW-1:0]   head_wdata;

  logic [15:0]     kx_mem [ENTRIES];
  logic [15:0]     ky_mem [ENTRIES];
  logic [31:0]     val_mem [ENTRIES];
  logic [EW:0]     lnk_mem [ENTRIES];
  logic [EW-1:0]   fs_mem [ENTRIES];
  logic [15:0]     kx_q;
  logic [15:0]     ky_q;
  logic [31:0]     val_q;
  logic [EW:0]     lnk_q;
  logic [EW-1:0]   fs_q;
  logic [EW-1:0]   ent_raddr;

  logic            key_we;
  logic            val_we;
  logic [EW-1:0]   val_waddr;
  logic            lnk_we;
  logic [EW-1:0]   lnk_waddr;
  logic [EW:0]     lnk_wdata;
  logic            fs_we;

  logic [EW-1:0]   cur;
  logic [EW-1:0]   prev;
  logic            prev_ok;
  logic            hit;
  logic [EW-1:0]   cur_link;
  logic            cur_lok;
  logic [31:0]     cur_val;
  logic [EW-1:0]   steps;
  logic [CW-1:0]   count;
  logic [CW-1:0]   sp;
  logic [CW-1:0]   hwm;
  logic [EW-1:0]   slot;
  logic [EW-1:0]   slot_sel;
  logic            alloc;
  logic            drop;
  logic            match;
  logic [2:0]      res_status;
  logic [31:0]     res_value;
  logic            out_valid;
  logic            res_load;

  assign empty    = !out_valid;
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign slot_sel = (sp != '0) ? fs_q : hwm[EW-1:0];
  assign alloc    = (state == S_DECIDE) && (req.operation == OP_INSERT) && !hit
                    && (count != CW'(ENTRIES));
  assign drop     = (state == S_DECIDE) && (req.operation == OP_REMOVE) && hit;
  assign match    = (kx_q == req.key_x) && (ky_q == req.key_y);
  assign res_load = (state == S_DONE) && (!out_valid || pop);

  always_comb begin
    unique case (state)
      S_HEAD:  ent_raddr = head_q;
      S_READ:  ent_raddr = lnk_q[EW-1:0];
      default: ent_raddr = cur;
    endcase
    head_we    = (alloc || drop) && !prev_ok;
    head_wdata = alloc ? slot_sel : cur_link;
    key_we     = alloc;
    val_we     = alloc || ((state == S_DECIDE) && (req.operation == OP_INSERT) && hit);
    val_waddr  = hit ? cur : slot_sel;
    fs_we      = drop;
    lnk_we     = 1'b0;
    lnk_waddr  = prev;
    lnk_wdata  = {cur_lok, cur_link};
    if (alloc) begin
      lnk_we    = 1'b1;
      lnk_waddr = slot_sel;
      lnk_wdata = '0;
    end else if (drop && prev_ok) begin
      lnk_we = 1'b1;
    end else if (state == S_LINK) begin
      lnk_we    = 1'b1;
      lnk_wdata = {1'b1, slot};
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[req.bucket] <= head_wdata;
    end
    head_q <= head_mem[q_data.bucket];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      kx_mem[slot_sel] <= req.key_x;
      ky_mem[slot_sel] <= req.key_y;
    end
    if (val_we) begin
      val_mem[val_waddr] <= req.value_in;
    end
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    kx_q  <= kx_mem[ent_raddr];
    ky_q  <= ky_mem[ent_raddr];
    val_q <= val_mem[ent_raddr];
    lnk_q <= lnk_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      fs_mem[sp[EW-1:0]] <= cur;
    end
    fs_q <= fs_mem[EW'(sp - 1'b1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_valid <= '0;
      count      <= '0;
      sp         <= '0;
      hwm        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            req     <= q_data;
            steps   <= '0;
            prev_ok <= 1'b0;
            hit     <= 1'b0;
            state   <= S_HEAD;
          end
        end
        S_HEAD: begin
          cur <= head_q;
          state <= head_valid[req.bucket] ? S_READ : S_DECIDE;
        end
        S_READ: begin
          if (match) begin
            hit      <= 1'b1;
            cur_link <= lnk_q[EW-1:0];
            cur_lok  <= lnk_q[EW];
            cur_val  <= val_q;
            state    <= S_DECIDE;
          end else begin
            prev    <= cur;
            prev_ok <= 1'b1;
            cur     <= lnk_q[EW-1:0];
            steps   <= steps + 1'b1;
            if (!lnk_q[EW] || steps == EW'(ENTRIES - 1)) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          res_value <= (req.operation == OP_LOOKUP && hit) ? cur_val : '0;
          state     <= (alloc && prev_ok) ? S_LINK : S_DONE;
          unique case (req.operation)
            OP_INSERT: begin
              if (hit) begin
                res_status <= ST_UPDATED;
              end else if (!alloc) begin
                res_status <= ST_FULL;
              end else begin
                res_status <= ST_NEW;
                slot       <= slot_sel;
                count      <= count + 1'b1;
                if (sp != '0) begin
                  sp <= sp - 1'b1;
                end else begin
                  hwm <= hwm + 1'b1;
                end
                if (!prev_ok) begin
                  head_valid[req.bucket] <= 1'b1;
                end
              end
            end
            OP_LOOKUP: begin
              res_status <= hit ? ST_FOUND : ST_ABSENT;
            end
            OP_REMOVE: begin
              if (hit) begin
                res_status <= ST_REMOVED;
                sp         <= sp + 1'b1;
                if (count != '0) begin
                  count <= count - 1'b1;
                end
                if (!prev_ok) begin
                  head_valid[req.bucket] <= cur_lok;
                end
              end else begin
                res_status <= ST_ABSENT;
              end
            end
            default: begin
              res_status <= ST_ABSENT;
            end
          endcase
        end
        S_LINK: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            status      <= res_status;
            value_out   <= res_value;
            entry_total <= 9'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/coordinate_hash_map.sv
// Path: a request is registered in the front, held in the two-entry queue, then taken
// by the back through S_IDLE, S_HEAD, one S_READ per chain entry visited, S_DECIDE,
// S_LINK when a new key is appended behind an existing entry, and S_DONE.
// The back handles one request at a time over the single read port of the entry memories,
// while the front and queue can take new ones; S_DONE waits until the output is free.
// Reset: synchronous, active high; empties all buckets, the pool, the queue and the output.
module coordinate_hash_map import chm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation,
  input  logic signed [15:0] key_x,
  input  logic signed [15:0] key_y,
  input  logic [31:0]        value_in,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic [31:0]        value_out,
  output logic [8:0]         entry_total
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  req_t q_in;
  req_t q_out;

  chm_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .operation(operation), .key_x(key_x), .key_y(key_y), .value_in(value_in),
    .q_push(q_push), .q_data(q_in), .q_full(q_full)
  );

  chm_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_in), .full(q_full),
    .pop(q_pop), .dout(q_out), .empty(q_empty)
  );

  chm_back u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
    .empty(empty), .pop(pop), .status(status), .value_out(value_out),
    .entry_total(entry_total)
  );

endmodule

### hdl/chm_checker.sv
`include "coordinate_hash_map_macros.svh"

module chm_checker import chm_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  status,
  input logic [31:0] value_out,
  input logic [8:0]  entry_total
);

  `CHM_ASSERT_NEXT(a_take, push && !full, full, "request not held")
  `CHM_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(status), "result dropped")
  `CHM_ASSERT_NOW(a_code, !empty, status <= ST_FULL, "bad status code")
  `CHM_ASSERT_NOW(a_zero, !empty && status != ST_FOUND, value_out == 32'd0, "stray value")
  `CHM_ASSERT_NOW(a_new, !empty && status == ST_NEW, entry_total != 9'd0 || ENTRIES >= 512,
                  "count not raised")

endmodule

bind coordinate_hash_map chm_checker u_chk (.*);
